// ===== design/b32e_pkg.sv =====
// Shared types, constants and the alphabet lookup for the base32 encoder.
`timescale 1ns / 1ps

package b32e_pkg;

  localparam int unsigned GroupBytes = 5;
  localparam int unsigned GroupChars = 8;
  localparam int unsigned GroupBits  = 8 * GroupBytes;

  localparam logic [7:0] PadChar   = 8'h3D;
  localparam logic [7:0] AlphaBase = 8'h41;  // 'A'
  localparam logic [7:0] DigitBase = 8'h32;  // '2'
  localparam logic [4:0] AlphaLen  = 5'd26;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       group_last;
    logic       stream_last;
  } out_item_t;

  // One finished group, left aligned, as handed from the front to the back.
  typedef struct packed {
    logic [GroupBits-1:0] bits;
    logic [3:0]           data_cnt;
    logic                 fin;
  } group_t;

  // Maps a 5-bit field onto the alphabet A-Z, 2-7.
  function automatic logic [7:0] sym_char(input logic [4:0] idx);
    logic [7:0] ch;
    if (idx < AlphaLen) begin
      ch = AlphaBase + {3'b000, idx};
    end else begin
      ch = DigitBase + {3'b000, idx - AlphaLen};
    end
    return ch;
  endfunction

  // Number of data characters for a group of n bytes.
  function automatic logic [3:0] data_chars(input logic [2:0] n);
    logic [3:0] cnt;
    case (n)
      3'd1:    cnt = 4'd2;
      3'd2:    cnt = 4'd4;
      3'd3:    cnt = 4'd5;
      3'd4:    cnt = 4'd7;
      3'd5:    cnt = 4'd8;
      default: cnt = 4'd0;
    endcase
    return cnt;
  endfunction

endpackage

// ===== design/b32e_front.sv =====
// Front end: packs input bytes into groups and pushes finished groups.
`timescale 1ns / 1ps

module b32e_front import b32e_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  in_item_t data_i,
  output logic     grp_push_o,
  output group_t   grp_o,
  input  logic     grp_full_i
);

  logic [31:0] group_q, group_d;
  logic [2:0]  held_q, held_d;
  logic [2:0]  held_eff;
  logic [2:0]  n;
  logic [39:0] acc;
  logic [39:0] aligned;
  logic        accept;
  logic        done;

  assign full     = grp_full_i;
  assign accept   = push && !grp_full_i;
  assign held_eff = (held_q > 3'd4) ? 3'd0 : held_q;
  assign n        = held_eff + 3'd1;
  assign acc      = {group_q, data_i.data_byte};
  assign done     = (n == 3'd5) || data_i.final_byte;

  always_comb begin
    case (n)
      3'd1:    aligned = {acc[7:0], 32'h0};
      3'd2:    aligned = {acc[15:0], 24'h0};
      3'd3:    aligned = {acc[23:0], 16'h0};
      3'd4:    aligned = {acc[31:0], 8'h0};
      default: aligned = acc;
    endcase
  end

  assign grp_push_o     = accept && done;
  assign grp_o.bits     = aligned;
  assign grp_o.data_cnt = data_chars(n);
  assign grp_o.fin      = data_i.final_byte;

  always_comb begin
    group_d = group_q;
    held_d  = held_q;
    if (accept) begin
      if (done) begin
        group_d = '0;
        held_d  = '0;
      end else begin
        group_d = acc[31:0];
        held_d  = n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q <= '0;
      held_q  <= '0;
    end else begin
      group_q <= group_d;
      held_q  <= held_d;
    end
  end

endmodule

// ===== design/b32e_gqueue.sv =====
// Two-entry queue of finished groups between the front and the back.
`timescale 1ns / 1ps

module b32e_gqueue import b32e_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   wr_i,
  input  group_t wr_data_i,
  output logic   full_o,
  input  logic   rd_i,
  output group_t rd_data_o,
  output logic   empty_o
);

  group_t     mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_wr;
  logic       do_rd;

  assign full_o    = (cnt_q == 2'd2);
  assign empty_o   = (cnt_q == 2'd0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_wr ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_rd ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== design/b32e_back.sv =====
// Back end: walks a group one character per cycle into the output register while it is free or popped.
`timescale 1ns / 1ps

module b32e_back import b32e_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  group_t    grp_i,
  input  logic      grp_empty_i,
  output logic      grp_pop_o,
  output logic      empty,
  input  logic      pop,
  output out_item_t data_o
);

  group_t     cur_q;
  logic       busy_q, busy_d;
  logic [2:0] idx_q, idx_d;
  logic       oval_q, oval_d;
  out_item_t  out_q;
  out_item_t  char_d;
  logic       advance;
  logic       last_char;
  logic       load;
  logic [39:0] shifted;

  assign advance   = busy_q && (!oval_q || pop);
  assign last_char = (idx_q == 3'd7);
  assign load      = (!busy_q || (advance && last_char)) && !grp_empty_i;
  assign grp_pop_o = load;

  // Field k sits at bit 35 - 5k of the left aligned group.
  assign shifted = cur_q.bits >> (6'd35 - 6'(idx_q) * 6'd5);

  always_comb begin
    if ({1'b0, idx_q} < cur_q.data_cnt) begin
      char_d.out_char = sym_char(shifted[4:0]);
    end else begin
      char_d.out_char = PadChar;
    end
    char_d.group_last  = last_char;
    char_d.stream_last = last_char && cur_q.fin;
  end

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    oval_d = oval_q && !pop;
    if (advance) begin
      oval_d = 1'b1;
      idx_d  = idx_q + 3'd1;
      if (last_char) begin
        busy_d = 1'b0;
      end
    end
    if (load) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= grp_i;
    end
    if (advance) begin
      out_q <= char_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      oval_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      oval_q <= oval_d;
    end
  end

  assign empty  = !oval_q;
  assign data_o = out_q;

  a_idle_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (idx_q == 3'd0))
    else $error("character index moved while no group is loaded");

  a_stream_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (oval_q && out_q.stream_last) |-> out_q.group_last)
    else $error("stream end flagged off a group boundary");

  a_load_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !(advance && last_char)) |-> !grp_pop_o)
    else $error("new group taken while the current one is unfinished");

endmodule

// ===== design/base32_encoder.sv =====
// Top level of the base32 encoder: byte packer, group queue and serializer.
`timescale 1ns / 1ps
//
//  Channel | Handshake     | Payload              | Transfer when
//  --------+---------------+----------------------+-----------------------
//  input   | push / full   | data_i  (in_item_t)  | push high, full low
//  result  | empty / pop   | data_o  (out_item_t) | pop high, empty low
//
//  A byte is taken in every cycle while the group queue has room. While both
//  queue entries are taken, full is high and every byte waits, closing or not.
//  The serializer gives one character per cycle while the result is popped or
//  the output register is empty, and each group yields eight characters.
//  The two-entry group queue lets the packer run up to two groups ahead of
//  the serializer; full rises only when both entries are taken.
//  Reset is asynchronous and active low; it clears the packer, the queue
//  pointers and the output register's valid bit. There is no clearing pass.
//  A stalled result holds in the output register while the serializer waits.
//
// The port names push, full, empty and pop are fixed by the queue interface.

module base32_encoder import b32e_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  data_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t data_o
);

  // Finished groups leave the packer on grp_push and are held in the queue
  // until the serializer is ready to walk through their eight characters.
  logic   grp_push;
  logic   grp_full;
  logic   grp_pop;
  logic   grp_empty;
  group_t grp_in;
  group_t grp_head;

  b32e_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .data_i     (data_i),
    .grp_push_o (grp_push),
    .grp_o      (grp_in),
    .grp_full_i (grp_full)
  );

  b32e_gqueue u_gqueue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (grp_push),
    .wr_data_i (grp_in),
    .full_o    (grp_full),
    .rd_i      (grp_pop),
    .rd_data_o (grp_head),
    .empty_o   (grp_empty)
  );

  // The serializer owns the output register, so a result waiting on pop
  // blocks the packer from taking further bytes only once the group queue is full.
  b32e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_i       (grp_head),
    .grp_empty_i (grp_empty),
    .grp_pop_o   (grp_pop),
    .empty       (empty),
    .pop         (pop),
    .data_o      (data_o)
  );

endmodule

// ===== sim/b32e_char_checker.sv =====
// Scoreboard for the base32 encoder: predicts each character and checks the result channel.
`timescale 1ns / 1ps

module b32e_char_checker import b32e_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  in_item_t    data_i,
  input  logic        empty,
  input  logic        pop,
  input  out_item_t   data_o,
  output int unsigned errors_o,
  output int unsigned pending_o
);

  localparam logic [255:0] SymTable = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";
  localparam logic [7:0]   PadSym   = 8'h3D;

  out_item_t   expected_chars[$];
  logic [31:0] pend_bits;
  logic [2:0]  pend_count;
  int unsigned mismatches;

  assign errors_o = mismatches;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Packs one byte and, when a group closes, queues its eight characters.
  task automatic encode_byte(input in_item_t item);
    logic [39:0] grp;
    logic [2:0]  n;
    logic [3:0]  nchars;
    logic [4:0]  idx;
    out_item_t   ch;
    n = (pend_count > 3'd4) ? 3'd1 : pend_count + 3'd1;
    if (n < 3'd5 && !item.final_byte) begin
      pend_bits  = {pend_bits[23:0], item.data_byte};
      pend_count = n;
      return;
    end
    grp = {pend_bits, item.data_byte};
    grp = grp << (8 * (5 - n));
    case (n)
      3'd1:    nchars = 4'd2;
      3'd2:    nchars = 4'd4;
      3'd3:    nchars = 4'd5;
      3'd4:    nchars = 4'd7;
      default: nchars = 4'd8;
    endcase
    for (int k = 0; k < 8; k++) begin
      idx = grp[39 - 5 * k -: 5];
      ch.out_char    = (k < nchars) ? SymTable[255 - 8 * idx -: 8] : PadSym;
      ch.group_last  = (k == 7);
      ch.stream_last = (k == 7) && item.final_byte;
      expected_chars.push_back(ch);
    end
    pend_bits  = '0;
    pend_count = '0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      expected_chars.delete();
      pend_bits  = '0;
      pend_count = '0;
    end else begin
      if (pop && !empty) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("unexpected character", data_o.out_char, 0);
        end else begin
          want = expected_chars.pop_front();
          if (data_o.out_char !== want.out_char)
            report_mismatch("out_char", data_o.out_char, want.out_char);
          if (data_o.group_last !== want.group_last)
            report_mismatch("group_last", data_o.group_last, want.group_last);
          if (data_o.stream_last !== want.stream_last)
            report_mismatch("stream_last", data_o.stream_last, want.stream_last);
        end
      end
      if (push && !full) begin
        encode_byte(data_i);
      end
    end
    pending_o = expected_chars.size();
  end

  initial begin
    mismatches = 0;
    pending_o  = 0;
  end

endmodule

// ===== sim/tb.sv =====
// Top of the base32 encoder testbench: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import b32e_pkg::*;

  // Run length in items and the guard on total cycles. The limit leaves
  // ample room for the slowest correct run.
  localparam int unsigned RandomItems = 455;
  localparam int unsigned CycleLimit  = 200000;
  // The receiver stops popping for a long stretch so that the group queue
  // fills and the encoder must push back on the byte side.
  localparam int unsigned HoldStart   = 500;
  localparam int unsigned HoldCycles  = 300;
  // Receiver cycles in which it pops on every cycle.
  localparam int unsigned CalmStart   = 900;
  localparam int unsigned CalmEnd     = 1150;
  // Random items during which the sender never idles, and where it pauses.
  localparam int unsigned SendCalmLo  = 150;
  localparam int unsigned SendCalmHi  = 250;
  localparam int unsigned PauseAt     = 400;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        push   = 1'b0;
  logic        full;
  in_item_t    data_i = '0;
  logic        empty;
  logic        pop    = 1'b0;
  out_item_t   data_o;
  int unsigned errors;
  int unsigned pending;
  int unsigned cycle_count;

  base32_encoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .data_i (data_i),
    .empty  (empty),
    .pop    (pop),
    .data_o (data_o)
  );

  // The checker sees both channels exactly as the encoder does and keeps
  // the expected characters; the top only reads its two counters.
  b32e_char_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .data_i    (data_i),
    .empty     (empty),
    .pop       (pop),
    .data_o    (data_o),
    .errors_o  (errors),
    .pending_o (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Offers one byte and holds it until a transfer happens. Entered and left
  // at a falling edge. An idle gap first lowers push, and time always passes
  // before push is raised again, so push never sees two updates in one step.
  task automatic send_byte(input logic [7:0] b, input logic fin, input bit may_idle);
    if (may_idle && $urandom_range(99) < 24) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    push   <= 1'b1;
    data_i <= '{data_byte: b, final_byte: fin};
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
  endtask

  // Stops offering bytes until every predicted character has been popped.
  // The extra falling edge keeps the lowering of push apart from the next
  // raise.
  task automatic wait_drained();
    push <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  // Byte side: directed streams covering every group length, then random
  // streams, each closed by a byte that carries the final flag.
  initial begin : byte_side
    int unsigned sent;
    int unsigned len;
    bit          paused;
    sent   = 0;
    paused = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // One-byte streams at both extremes: two characters and six pads.
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b1);
    // Two, three and four byte streams: four, five and seven characters.
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'hAA, 1'b1, 1'b1);
    send_byte(8'h55, 1'b0, 1'b1);
    send_byte(8'hAA, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h01, 1'b1, 1'b1);
    // The final flag on the fifth byte: a full group with no padding.
    send_byte(8'hF8, 1'b0, 1'b1);
    send_byte(8'h3E, 1'b0, 1'b1);
    send_byte(8'h0F, 1'b0, 1'b1);
    send_byte(8'h83, 1'b0, 1'b1);
    send_byte(8'hE0, 1'b1, 1'b1);
    // A group filled without the final flag, then a one-byte tail.
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h44, 1'b0, 1'b1);
    send_byte(8'h32, 1'b0, 1'b1);
    send_byte(8'h14, 1'b0, 1'b1);
    send_byte(8'hC7, 1'b0, 1'b1);
    send_byte(8'h80, 1'b1, 1'b1);

    // Let the directed part finish completely before the random streams.
    wait_drained();

    // Random streams: mostly short ones, so that every partial group length
    // recurs often, with an occasional long one spanning several groups.
    while (sent < RandomItems) begin
      len = ($urandom_range(99) < 10) ? $urandom_range(13, 30) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        send_byte(8'($urandom_range(255)), i == len - 1,
                  !(sent >= SendCalmLo && sent < SendCalmHi));
        sent++;
      end
      if (!paused && sent >= PauseAt) begin
        paused = 1'b1;
        wait_drained();
      end
    end

    // All bytes are in: wait for the last characters, then a short drain so
    // that any stray extra character is still caught.
    wait_drained();
    repeat (40) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("** base32_encoder: PASSED **");
    end else begin
      $display("** base32_encoder: FAILED **");
    end
    $finish;
  end

  // Result side: pops at random about three quarters of the time, with one calm
  // stretch that pops every cycle and one long hold-off.
  initial begin : result_side
    int unsigned rx_cycle;
    rx_cycle = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      rx_cycle++;
      if (rx_cycle == HoldStart) begin
        pop <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      if (rx_cycle >= CalmStart && rx_cycle < CalmEnd) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(99) >= 24);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("** base32_encoder: FAILED **");
    $finish;
  end

endmodule
